### design/rsdz_pkg.sv
// ----------------------------------------------------------------------------
// rsdz_pkg
// Shared widths, constants and cell state types of the radial stick dead zone.
// ----------------------------------------------------------------------------
package rsdz_pkg;

  localparam int unsigned SQ_CELLS  = 16;
  localparam int unsigned DIV_CELLS = 15;

  localparam logic [14:0] FULL_SCALE   = 15'h7fff;
  localparam logic [14:0] DZ_MAX       = 15'h7ffe;
  localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;

  localparam logic REG_LEFT_DZ  = 1'b0;
  localparam logic REG_RIGHT_DZ = 1'b1;

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] root;
    logic [31:0] rad;
  } sqrt_cell_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [14:0] lq;
  } div_cell_t;

endpackage

### design/rsdz_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsdz_sqrt_cell
// One digit step of the integer square root; resolves one root bit per cycle.
// ----------------------------------------------------------------------------
module rsdz_sqrt_cell (
  input  logic                clk_i,
  input  rsdz_pkg::sqrt_cell_t st_i,
  output rsdz_pkg::sqrt_cell_t st_o
);

  logic [18:0] trial;
  logic [18:0] part;
  logic [18:0] diff;
  logic        ge;
  rsdz_pkg::sqrt_cell_t st_d;
  rsdz_pkg::sqrt_cell_t st_q;

  always_comb begin
    part  = {st_i.rem, st_i.rad[31:30]};
    trial = {1'b0, st_i.root, 2'b01};
    ge    = part >= trial;
    diff  = part - trial;
    st_d.rem  = ge ? diff[16:0] : part[16:0];
    st_d.root = {st_i.root[14:0], ge};
    st_d.rad  = {st_i.rad[29:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

### design/rsdz_div_cell.sv
// ----------------------------------------------------------------------------
// rsdz_div_cell
// One restoring division step; shifts one quotient bit in per cycle.
// ----------------------------------------------------------------------------
module rsdz_div_cell (
  input  logic               clk_i,
  input  rsdz_pkg::div_cell_t st_i,
  input  logic [15:0]        divisor_i,
  output rsdz_pkg::div_cell_t st_o
);

  logic [16:0] part;
  logic [16:0] diff;
  logic        ge;
  rsdz_pkg::div_cell_t st_d;
  rsdz_pkg::div_cell_t st_q;

  always_comb begin
    part = {st_i.rem, st_i.lq[14]};
    ge   = part >= {1'b0, divisor_i};
    diff = part - {1'b0, divisor_i};
    st_d.rem = ge ? diff[15:0] : part[15:0];
    st_d.lq  = {st_i.lq[13:0], ge};
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

### design/radial_stick_dead_zone_unit.sv
// ----------------------------------------------------------------------------
// radial_stick_dead_zone_unit
// Radial thumb-stick dead zone with magnitude rescale, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one sample in every clock cycle and busy stays low. Each
// result appears on the result ports, in the order of the samples, for one
// cycle with out_valid_o high. The pipeline holds the chain of sixteen square
// root cells, then the chain of fifteen divider cells for the scale, then two
// parallel chains of fifteen divider cells for the axes, one bit per cell.
module radial_stick_dead_zone_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic               stick_select_i,
  input  logic               connected_i,
  output logic               out_valid_o,
  output logic signed [15:0] scaled_x_o,
  output logic signed [15:0] scaled_y_o,
  output logic [14:0]        scaled_magnitude_o,
  output logic               in_dead_zone_o
);

  localparam int unsigned SQ  = rsdz_pkg::SQ_CELLS;
  localparam int unsigned DV  = rsdz_pkg::DIV_CELLS;
  localparam int unsigned LATENCY = 5 + SQ + 2 * DV;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        conn;
    logic [14:0] dz;
  } raw_sb_t;

  typedef struct packed {
    logic        xneg;
    logic [15:0] xmag;
    logic        yneg;
    logic [15:0] ymag;
    logic [15:0] m;
    logic [15:0] dvs;
    logic        dead;
  } mag_sb_t;

  typedef struct packed {
    logic        xneg;
    logic        yneg;
    logic [15:0] m;
    logic [14:0] s;
    logic        dead;
  } axis_sb_t;

  logic [14:0] left_dz_q;
  logic [14:0] right_dz_q;
  logic        wr_en;
  logic        accept;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_dz_q  <= rsdz_pkg::LEFT_DZ_RST;
      right_dz_q <= rsdz_pkg::RIGHT_DZ_RST;
    end else if (wr_en) begin
      case (paddr[2])
        rsdz_pkg::REG_LEFT_DZ:  left_dz_q  <= pwdata[14:0];
        rsdz_pkg::REG_RIGHT_DZ: right_dz_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rsdz_pkg::REG_LEFT_DZ:  prdata = {17'd0, left_dz_q};
      rsdz_pkg::REG_RIGHT_DZ: prdata = {17'd0, right_dz_q};
      default:                prdata = 32'd0;
    endcase
  end

  // Input stage: squares and dead-zone select.
  logic [14:0] dz_sel;
  logic        a_vld_q;
  raw_sb_t     a_sb_q;
  logic [30:0] a_xx_q;
  logic [30:0] a_yy_q;

  always_comb begin
    dz_sel = stick_select_i ? right_dz_q : left_dz_q;
    if (dz_sel == rsdz_pkg::FULL_SCALE) begin
      dz_sel = rsdz_pkg::DZ_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    a_sb_q.x    <= axis_x_i;
    a_sb_q.y    <= axis_y_i;
    a_sb_q.conn <= connected_i;
    a_sb_q.dz   <= dz_sel;
    a_xx_q      <= 31'(unsigned'(32'(axis_x_i * axis_x_i)));
    a_yy_q      <= 31'(unsigned'(32'(axis_y_i * axis_y_i)));
  end

  // Square root chain.
  rsdz_pkg::sqrt_cell_t b_st_q;
  rsdz_pkg::sqrt_cell_t sq_st [SQ];
  raw_sb_t              sq_sb_q [SQ+1];
  logic [SQ:0]          sq_vld_q;

  always_ff @(posedge clk_i) begin
    b_st_q.rem  <= '0;
    b_st_q.root <= '0;
    b_st_q.rad  <= {1'b0, a_xx_q} + {1'b0, a_yy_q};
    sq_sb_q[0]  <= a_sb_q;
    for (int i = 0; i < SQ; i++) begin
      sq_sb_q[i+1] <= sq_sb_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= '0;
    end else begin
      sq_vld_q <= {sq_vld_q[SQ-1:0], a_vld_q};
    end
  end

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    if (g == 0) begin : g_first
      rsdz_sqrt_cell u_cell (.clk_i(clk_i), .st_i(b_st_q), .st_o(sq_st[g]));
    end else begin : g_next
      rsdz_sqrt_cell u_cell (.clk_i(clk_i), .st_i(sq_st[g-1]), .st_o(sq_st[g]));
    end
  end

  // Dead-zone decision and rescale numerator.
  raw_sb_t     sq_end;
  logic [15:0] m_root;
  logic [14:0] m_clip;
  logic [14:0] m_diff;
  logic [29:0] num;
  mag_sb_t     d_sb_d;

  rsdz_pkg::div_cell_t d_st_q;
  rsdz_pkg::div_cell_t dv_st [DV];
  mag_sb_t             ds_sb_q [DV+1];
  logic [DV:0]         ds_vld_q;

  always_comb begin
    sq_end  = sq_sb_q[SQ];
    m_root  = sq_st[SQ-1].root;
    m_clip  = m_root[15] ? rsdz_pkg::FULL_SCALE : m_root[14:0];
    m_diff  = m_clip - sq_end.dz;
    num     = {m_diff, 15'd0} - {15'd0, m_diff};
    d_sb_d.xneg = sq_end.x[15];
    d_sb_d.xmag = sq_end.x[15] ? 16'(-sq_end.x) : sq_end.x;
    d_sb_d.yneg = sq_end.y[15];
    d_sb_d.ymag = sq_end.y[15] ? 16'(-sq_end.y) : sq_end.y;
    d_sb_d.m    = m_root;
    d_sb_d.dvs  = {1'b0, rsdz_pkg::FULL_SCALE - sq_end.dz};
    d_sb_d.dead = !sq_end.conn || (m_root <= {1'b0, sq_end.dz});
  end

  always_ff @(posedge clk_i) begin
    d_st_q.rem <= {1'b0, num[29:15]};
    d_st_q.lq  <= num[14:0];
    ds_sb_q[0] <= d_sb_d;
    for (int i = 0; i < DV; i++) begin
      ds_sb_q[i+1] <= ds_sb_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ds_vld_q <= '0;
    end else begin
      ds_vld_q <= {ds_vld_q[DV-1:0], sq_vld_q[SQ]};
    end
  end

  for (genvar g = 0; g < DV; g++) begin : g_sdiv
    if (g == 0) begin : g_first
      rsdz_div_cell u_cell (
        .clk_i(clk_i), .st_i(d_st_q), .divisor_i(ds_sb_q[g].dvs), .st_o(dv_st[g])
      );
    end else begin : g_next
      rsdz_div_cell u_cell (
        .clk_i(clk_i), .st_i(dv_st[g-1]), .divisor_i(ds_sb_q[g].dvs), .st_o(dv_st[g])
      );
    end
  end

  // Axis products and axis division chains.
  mag_sb_t     ds_end;
  logic [14:0] s_val;
  logic [30:0] prod_x;
  logic [30:0] prod_y;
  axis_sb_t    p_sb_d;

  rsdz_pkg::div_cell_t px_st_q;
  rsdz_pkg::div_cell_t py_st_q;
  rsdz_pkg::div_cell_t ax_st [DV];
  rsdz_pkg::div_cell_t ay_st [DV];
  axis_sb_t            pr_sb_q [DV+1];
  logic [DV:0]         pr_vld_q;

  always_comb begin
    ds_end = ds_sb_q[DV];
    s_val  = dv_st[DV-1].lq;
    prod_x = 31'(ds_end.xmag * s_val);
    prod_y = 31'(ds_end.ymag * s_val);
    p_sb_d.xneg = ds_end.xneg;
    p_sb_d.yneg = ds_end.yneg;
    p_sb_d.m    = ds_end.m;
    p_sb_d.s    = s_val;
    p_sb_d.dead = ds_end.dead;
  end

  always_ff @(posedge clk_i) begin
    px_st_q.rem <= prod_x[30:15];
    px_st_q.lq  <= prod_x[14:0];
    py_st_q.rem <= prod_y[30:15];
    py_st_q.lq  <= prod_y[14:0];
    pr_sb_q[0]  <= p_sb_d;
    for (int i = 0; i < DV; i++) begin
      pr_sb_q[i+1] <= pr_sb_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= '0;
    end else begin
      pr_vld_q <= {pr_vld_q[DV-1:0], ds_vld_q[DV]};
    end
  end

  for (genvar g = 0; g < DV; g++) begin : g_adiv
    if (g == 0) begin : g_first
      rsdz_div_cell u_xcell (
        .clk_i(clk_i), .st_i(px_st_q), .divisor_i(pr_sb_q[g].m), .st_o(ax_st[g])
      );
      rsdz_div_cell u_ycell (
        .clk_i(clk_i), .st_i(py_st_q), .divisor_i(pr_sb_q[g].m), .st_o(ay_st[g])
      );
    end else begin : g_next
      rsdz_div_cell u_xcell (
        .clk_i(clk_i), .st_i(ax_st[g-1]), .divisor_i(pr_sb_q[g].m), .st_o(ax_st[g])
      );
      rsdz_div_cell u_ycell (
        .clk_i(clk_i), .st_i(ay_st[g-1]), .divisor_i(pr_sb_q[g].m), .st_o(ay_st[g])
      );
    end
  end

  // Output register.
  axis_sb_t    pr_end;
  logic [15:0] qx;
  logic [15:0] qy;
  logic [15:0] out_x_d;
  logic [15:0] out_y_d;
  logic [14:0] out_m_d;
  logic        out_vld_q;
  logic [15:0] out_x_q;
  logic [15:0] out_y_q;
  logic [14:0] out_m_q;
  logic        out_dead_q;

  always_comb begin
    pr_end = pr_sb_q[DV];
    qx     = {1'b0, ax_st[DV-1].lq};
    qy     = {1'b0, ay_st[DV-1].lq};
    if (pr_end.dead) begin
      out_x_d = '0;
      out_y_d = '0;
      out_m_d = '0;
    end else begin
      out_x_d = pr_end.xneg ? 16'(-qx) : qx;
      out_y_d = pr_end.yneg ? 16'(-qy) : qy;
      out_m_d = pr_end.s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= pr_vld_q[DV];
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_m_q    <= out_m_d;
    out_dead_q <= pr_end.dead;
  end

  assign out_valid_o        = out_vld_q;
  assign scaled_x_o         = out_x_q;
  assign scaled_y_o         = out_y_q;
  assign scaled_magnitude_o = out_m_q;
  assign in_dead_zone_o     = out_dead_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY out_valid_o)
    else $error("Result word missing at the expected cycle.");

  a_dead_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_dead_zone_o |->
      scaled_x_o == 16'd0 && scaled_y_o == 16'd0 && scaled_magnitude_o == 15'd0)
    else $error("Dead-zone word carries nonzero deflection.");

  a_live_mag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_dead_zone_o |-> scaled_magnitude_o != 15'd0)
    else $error("Word outside the dead zone has zero magnitude.");

endmodule
